/* src/rpvg_pkg.sv */
// Shared types and constants for the regular polygon vertex generator.
// Holds the CORDIC arctangent table in binary-angle units. No dependencies.
package rpvg_pkg;

  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic signed [33:0] QUARTER_TURN = 34'sh0_4000_0000;
  localparam logic signed [33:0] GAIN_INV_Q30 = 34'sd652032875;

  typedef logic signed [33:0] rot_t;
  typedef logic signed [35:0] vec_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:    v = 32'd536870912;
      5'd1:    v = 32'd316933406;
      5'd2:    v = 32'd167458907;
      5'd3:    v = 32'd85004756;
      5'd4:    v = 32'd42667331;
      5'd5:    v = 32'd21354465;
      5'd6:    v = 32'd10679838;
      5'd7:    v = 32'd5340245;
      5'd8:    v = 32'd2670163;
      5'd9:    v = 32'd1335087;
      5'd10:   v = 32'd667544;
      5'd11:   v = 32'd333772;
      5'd12:   v = 32'd166886;
      5'd13:   v = 32'd83443;
      5'd14:   v = 32'd41722;
      5'd15:   v = 32'd20861;
      5'd16:   v = 32'd10430;
      5'd17:   v = 32'd5215;
      5'd18:   v = 32'd2608;
      5'd19:   v = 32'd1304;
      5'd20:   v = 32'd652;
      5'd21:   v = 32'd326;
      5'd22:   v = 32'd163;
      5'd23:   v = 32'd81;
      5'd24:   v = 32'd41;
      5'd25:   v = 32'd20;
      5'd26:   v = 32'd10;
      5'd27:   v = 32'd5;
      5'd28:   v = 32'd3;
      5'd29:   v = 32'd1;
      5'd30:   v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* src/regular_polygon_vertex_generator.sv */
// Per item: the start-angle vectoring CORDIC runs alongside a bit-serial step
// divider in S_VEC, then one vertex per cycle is issued into the rotation pipeline
// while the output is not stalled. A new item is taken only in S_IDLE, after the last vertex.
// Vertices stream out of the rotation pipeline one per cycle while out_ready allows.
// rst_n is synchronous, active low; it clears the sequencer and all valid bits.
module regular_polygon_vertex_generator
  import rpvg_pkg::*;
#(
  parameter int MAX_SIDES    = 64,
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic        [31:0] in_radius,
  input  logic        [6:0]  in_sides,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_vertex_x,
  output logic signed [31:0] out_vertex_y,
  output logic        [5:0]  out_vertex_index,
  output logic               out_last
);

  localparam int DIV_CYCLES = 33;

  typedef enum logic [1:0] {S_IDLE, S_VEC, S_EMIT} state_t;

  state_t            state_r;
  logic        [5:0] cnt_r;
  vec_t              vx_r, vy_r;
  logic       [31:0] vz_r;
  logic              zero_r;
  logic        [7:0] rem_r;
  logic       [32:0] quo_r;
  logic        [6:0] n_r;
  logic       [31:0] az_r, step_r;
  logic        [5:0] k_r;
  logic signed [31:0] cx_r, cy_r;
  logic       [31:0] rad_r;

  logic adv;
  logic issue;
  logic in_xfer;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign adv      = !out_valid || out_ready;
  assign issue    = (state_r == S_EMIT) && adv;

  // input decode
  logic signed [32:0] dx, dy;
  logic        [6:0]  n_sat;
  assign dx = 33'(in_first_x) - 33'(in_center_x);
  assign dy = 33'(in_first_y) - 33'(in_center_y);
  always_comb begin
    n_sat = in_sides;
    if (in_sides < 7'd3) n_sat = 7'd3;
    if (in_sides > 7'(MAX_SIDES)) n_sat = 7'(MAX_SIDES);
  end

  // vectoring step and divider step
  vec_t        vxs, vys;
  logic [7:0]  rem_sh;
  logic        qbit;
  assign vxs    = vx_r >>> cnt_r[4:0];
  assign vys    = vy_r >>> cnt_r[4:0];
  assign rem_sh = {rem_r[6:0], quo_r[32]};
  assign qbit   = (rem_sh >= {1'b0, n_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      k_r     <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_VEC;
            cnt_r   <= '0;
            cx_r    <= in_center_x;
            cy_r    <= in_center_y;
            rad_r   <= in_radius;
            n_r     <= n_sat;
            zero_r  <= (dx == '0) && (dy == '0);
            vz_r    <= dy[32] ? HALF_TURN : '0;
            vx_r    <= dy[32] ? -36'(dy) : 36'(dy);
            vy_r    <= dy[32] ? -36'(dx) : 36'(dx);
            rem_r   <= '0;
            quo_r   <= {1'b1, 25'd0, n_sat >> 1};
          end
        end
        S_VEC: begin
          if (cnt_r < 6'(CORDIC_STEPS)) begin
            if (vy_r > 0) begin
              vx_r <= vx_r + vys;
              vy_r <= vy_r - vxs;
              vz_r <= vz_r + atan_val(cnt_r[4:0]);
            end else begin
              vx_r <= vx_r - vys;
              vy_r <= vy_r + vxs;
              vz_r <= vz_r - atan_val(cnt_r[4:0]);
            end
          end
          rem_r <= qbit ? rem_sh - {1'b0, n_r} : rem_sh;
          quo_r <= {quo_r[31:0], qbit};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(DIV_CYCLES - 1)) begin
            state_r <= S_EMIT;
            k_r     <= '0;
          end
        end
        S_EMIT: begin
          if (cnt_r == 6'(DIV_CYCLES)) begin
            // latch step once
            step_r <= quo_r[31:0];
            cnt_r <= '0;
          end
          if (issue) begin
            az_r <= ((cnt_r == 6'(DIV_CYCLES)) ? (zero_r ? '0 : vz_r) : az_r)
                    + ((cnt_r == 6'(DIV_CYCLES)) ? quo_r[31:0] : step_r);
            k_r  <= k_r + 6'd1;
            if ({1'b0, k_r} == n_r - 7'd1) state_r <= S_IDLE;
          end else if (cnt_r == 6'(DIV_CYCLES)) begin
            az_r <= zero_r ? '0 : vz_r;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // angle fold at issue
  logic [31:0] az_cur;
  logic signed [33:0] z_in;
  logic neg_in;
  assign az_cur = (cnt_r == 6'(DIV_CYCLES)) ? (zero_r ? '0 : vz_r) : az_r;
  always_comb begin
    z_in   = 34'(signed'(az_cur));
    neg_in = 1'b0;
    if (z_in > QUARTER_TURN || z_in < -QUARTER_TURN) begin
      neg_in = 1'b1;
      z_in   = (z_in > 0) ? z_in - 34'sh0_8000_0000 : z_in + 34'sh0_8000_0000;
    end
  end

  // rotation pipeline
  rot_t              px_r [0:CORDIC_STEPS];
  rot_t              py_r [0:CORDIC_STEPS];
  rot_t              pz_r [0:CORDIC_STEPS];
  logic              pv_r [0:CORDIC_STEPS];
  logic              pn_r [0:CORDIC_STEPS];
  logic              pl_r [0:CORDIC_STEPS];
  logic        [5:0] pk_r [0:CORDIC_STEPS];
  logic signed [31:0] pcx_r [0:CORDIC_STEPS];
  logic signed [31:0] pcy_r [0:CORDIC_STEPS];
  logic       [31:0] pr_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r[0] <= 1'b0;
    end else if (adv) begin
      pv_r[0]  <= issue;
      px_r[0]  <= GAIN_INV_Q30;
      py_r[0]  <= '0;
      pz_r[0]  <= z_in;
      pn_r[0]  <= neg_in;
      pl_r[0]  <= ({1'b0, k_r} == n_r - 7'd1);
      pk_r[0]  <= k_r;
      pcx_r[0] <= cx_r;
      pcy_r[0] <= cy_r;
      pr_r[0]  <= rad_r;
    end
  end

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_rot
    rot_t xs, ys, at;
    assign xs = px_r[j] >>> j;
    assign ys = py_r[j] >>> j;
    assign at = 34'(atan_val(5'(j)));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[j+1] <= 1'b0;
      end else if (adv) begin
        pv_r[j+1]  <= pv_r[j];
        if (pz_r[j] >= 0) begin
          px_r[j+1] <= px_r[j] - ys;
          py_r[j+1] <= py_r[j] + xs;
          pz_r[j+1] <= pz_r[j] - at;
        end else begin
          px_r[j+1] <= px_r[j] + ys;
          py_r[j+1] <= py_r[j] - xs;
          pz_r[j+1] <= pz_r[j] + at;
        end
        pn_r[j+1]  <= pn_r[j];
        pl_r[j+1]  <= pl_r[j];
        pk_r[j+1]  <= pk_r[j];
        pcx_r[j+1] <= pcx_r[j];
        pcy_r[j+1] <= pcy_r[j];
        pr_r[j+1]  <= pr_r[j];
      end
    end
  end

  // multiply stage
  localparam int L = CORDIC_STEPS;
  rot_t sn, cs;
  logic signed [66:0] mx_r, my_r;
  logic               mv_r, ml_r;
  logic        [5:0]  mk_r;
  logic signed [31:0] mcx_r, mcy_r;
  assign sn = pn_r[L] ? -py_r[L] : py_r[L];
  assign cs = pn_r[L] ? -px_r[L] : px_r[L];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (adv) begin
      mv_r  <= pv_r[L];
      mx_r  <= 67'(signed'({1'b0, pr_r[L]})) * 67'(sn);
      my_r  <= 67'(signed'({1'b0, pr_r[L]})) * 67'(cs);
      ml_r  <= pl_r[L];
      mk_r  <= pk_r[L];
      mcx_r <= pcx_r[L];
      mcy_r <= pcy_r[L];
    end
  end

  // round, add center, output register
  logic signed [66:0] ox, oy;
  assign ox = (mx_r + 67'sd536870912) >>> 30;
  assign oy = (my_r + 67'sd536870912) >>> 30;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid        <= mv_r;
      out_vertex_x     <= mcx_r + ox[31:0];
      out_vertex_y     <= mcy_r + oy[31:0];
      out_vertex_index <= mk_r;
      out_last         <= ml_r;
    end
  end

endmodule

/* src/rpvg_checker.sv */
// Port-level checks for the regular polygon vertex generator.
// Bound to the top level; uses no package.
module rpvg_props (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_vertex_x,
  input logic        [5:0]  out_vertex_index,
  input logic               out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_vertex_x))
    else $error("result changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_min_sides: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_vertex_index >= 6'd2)
    else $error("polygon closed with fewer than three vertices");

endmodule

bind regular_polygon_vertex_generator rpvg_props u_rpvg_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_vertex_x(out_vertex_x),
  .out_vertex_index(out_vertex_index), .out_last(out_last)
);
